[rtl/rmst_pkg.sv]
// Shared types, constants and the signed minimum function of the range-minimum segment tree.
// No dependencies.
package rmst_pkg;

    typedef logic signed [31:0] t_value;

    localparam t_value IDENTITY = 32'sh7FFF_FFFF;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    function automatic t_value f_smaller(input t_value a, input t_value b);
        return (b < a) ? b : a;
    endfunction

endpackage

[rtl/rmst_if.sv]
// Valid/ready channel interfaces of the segment tree: request in, minimum out.
// Depends on rmst_pkg.
interface rmst_in_if;
    import rmst_pkg::*;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [9:0]  position;
    t_value      value;
    logic [10:0] range_low;
    logic [10:0] range_high;

    modport source (output valid, operation, position, value, range_low, range_high,
                    input ready);
    modport sink   (input valid, operation, position, value, range_low, range_high,
                    output ready);
endinterface

interface rmst_out_if;
    import rmst_pkg::*;
    logic   valid;
    logic   ready;
    t_value minimum;

    modport source (output valid, minimum, input ready);
    modport sink   (input valid, minimum, output ready);
endinterface

[rtl/range_min_segment_tree_core.sv]
// Min segment tree over LEAVES leaves (power of two), heap numbered from 1, node n at address n.
// After reset the block sweeps all 2*LEAVES node addresses to the identity, one per cycle, and
// accepts no transfer during that pass. A write makes one sibling read and one parent write per
// level through the single node RAM port pair and one shared signed compare unit. A query is
// accepted, then makes one RAM read per visited node at each level, a final bound check and a
// result load; an empty range goes from the accept straight to the result load. The result
// load waits while the previous result is still held on the output.
// Depends on rmst_pkg, rmst_if and rmst_node_ram.
module range_min_segment_tree_core #(
    parameter int LEAVES = 1024
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rmst_in_if.sink    i_in,
    rmst_out_if.source o_out
);
    import rmst_pkg::*;

    localparam int LW = $clog2(LEAVES);
    localparam int AW = LW + 1;
    localparam int CW = AW + 1;
    localparam int DEPTH = 2 * LEAVES;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_W_RD, S_W_UP, S_Q_LO, S_Q_LOD, S_Q_HI, S_Q_HID, S_DONE
    } t_state;

    t_state          r_state, n_state;
    logic [AW-1:0]   r_clr, n_clr;
    logic [AW-1:0]   r_node, n_node;
    logic [CW-1:0]   r_lo, n_lo;
    logic [CW-1:0]   r_hi, n_hi;
    t_value          r_acc, n_acc;
    logic            r_out_valid, n_out_valid;
    t_value          r_min, n_min;

    logic            w_we;
    logic [AW-1:0]   w_waddr;
    t_value          w_wdata;
    logic [AW-1:0]   w_raddr;
    t_value          w_rdata;
    t_value          w_cmp;
    logic [31:0]     w_hi_clamp;
    logic            w_empty;
    logic            w_pos_ok;
    logic [AW-1:0]   w_leaf;
    logic [CW-1:0]   w_hi_dec;

    rmst_node_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_cmp      = f_smaller(r_acc, w_rdata);
    assign w_hi_clamp = (32'(i_in.range_high) > 32'(LEAVES)) ? 32'(LEAVES)
                                                                : 32'(i_in.range_high);
    assign w_empty    = 32'(i_in.range_low) >= w_hi_clamp;
    assign w_pos_ok   = 32'(i_in.position) < 32'(LEAVES);
    assign w_leaf     = AW'(32'(LEAVES) + 32'(i_in.position));
    assign w_hi_dec   = r_hi - CW'(1);

    assign i_in.ready    = (r_state == S_IDLE);
    assign o_out.valid   = r_out_valid;
    assign o_out.minimum = r_min;

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_node      = r_node;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_acc       = r_acc;
        n_min       = r_min;
        n_out_valid = r_out_valid && !o_out.ready;
        w_we        = 1'b0;
        w_waddr     = r_node;
        w_wdata     = r_acc;
        w_raddr     = r_node ^ AW'(1);
        unique case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                w_wdata = IDENTITY;
                n_clr   = r_clr + AW'(1);
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in.valid) begin
                    if (i_in.operation == OP_WRITE) begin
                        if (w_pos_ok) begin
                            w_we    = 1'b1;
                            w_waddr = w_leaf;
                            w_wdata = i_in.value;
                            n_node  = w_leaf;
                            n_acc   = i_in.value;
                            n_state = S_W_RD;
                        end
                    end else begin
                        n_acc   = IDENTITY;
                        n_lo    = CW'(32'(i_in.range_low) + 32'(LEAVES));
                        n_hi    = CW'(w_hi_clamp + 32'(LEAVES));
                        n_state = w_empty ? S_DONE : S_Q_LO;
                    end
                end
            end
            S_W_RD: begin
                w_raddr = r_node ^ AW'(1);
                n_state = (r_node == AW'(1)) ? S_IDLE : S_W_UP;
            end
            S_W_UP: begin
                w_we    = 1'b1;
                w_waddr = r_node >> 1;
                w_wdata = w_cmp;
                n_node  = r_node >> 1;
                n_acc   = w_cmp;
                n_state = S_W_RD;
            end
            S_Q_LO: begin
                w_raddr = AW'(r_lo);
                if (r_lo >= r_hi) begin
                    n_state = S_DONE;
                end else if (r_lo[0]) begin
                    n_lo    = r_lo + CW'(1);
                    n_state = S_Q_LOD;
                end else begin
                    n_state = S_Q_HI;
                end
            end
            S_Q_LOD: begin
                n_acc   = w_cmp;
                n_state = S_Q_HI;
            end
            S_Q_HI: begin
                w_raddr = AW'(w_hi_dec);
                if (r_hi[0]) begin
                    n_hi    = w_hi_dec;
                    n_state = S_Q_HID;
                end else begin
                    n_lo    = r_lo >> 1;
                    n_hi    = r_hi >> 1;
                    n_state = S_Q_LO;
                end
            end
            S_Q_HID: begin
                n_acc   = w_cmp;
                n_lo    = r_lo >> 1;
                n_hi    = r_hi >> 1;
                n_state = S_Q_LO;
            end
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_min       = r_acc;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
        r_node <= n_node;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_acc  <= n_acc;
        r_min  <= n_min;
    end

    a_clear_no_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !i_in.ready)
        else $error("input ready during clearing pass");

    a_walk_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_Q_LO || r_state == S_Q_HI) |-> (r_lo <= r_hi))
        else $error("query bounds crossed");

    a_node_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_W_RD || r_state == S_W_UP) |-> (r_node != '0))
        else $error("write walk left the tree");

    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !r_out_valid) |=> (r_out_valid && r_min == $past(r_acc)))
        else $error("result not loaded");

endmodule

[rtl/rmst_node_ram.sv]
// Node storage of the tree: one write port, one read port, registered read data.
// Depends on rmst_pkg.
module rmst_node_ram #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  rmst_pkg::t_value i_wdata,
    input  logic [AW-1:0]   i_raddr,
    output rmst_pkg::t_value o_rdata
);
    import rmst_pkg::*;

    t_value r_mem [DEPTH];
    t_value r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
